### rtl/ess_pkg.sv
// ess_pkg: widths, constants and the queue item type of the encoder speed sampler
// used by ess_front, ess_queue, ess_back and encoder_speed_sampler; no dependencies
`default_nettype none

package ess_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int DELTA_W = 18;
  localparam int SPEED_W = 36;
  localparam int ABS_W   = 17;   // magnitude of a corrected delta, up to 32769
  localparam int SCALE_W = 20;
  localparam int MAG_W   = ABS_W + SCALE_W;   // |delta| * 1e6

  // encoder counter range and derived wrap correction constants
  localparam int ESS_COUNT_MAX = 65535;
  localparam logic signed [DELTA_W-1:0] ESS_HALF = DELTA_W'(ESS_COUNT_MAX / 2);
  localparam logic signed [DELTA_W-1:0] ESS_WRAP = DELTA_W'(ESS_COUNT_MAX + 1);

  localparam logic [SCALE_W-1:0] ESS_SPEED_SCALE = 20'd1000000;
  localparam logic [TIME_W-1:0]  ESS_PERIOD_RST  = 32'd10000;

  localparam logic [SPEED_W-1:0] ESS_SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] ESS_SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic                      sampled;
    logic signed [DELTA_W-1:0] delta;
    logic [TIME_W-1:0]         dt;
  } ess_item_t;

endpackage

`default_nettype wire

### rtl/ess_front.sv
// ess_front: sample decision, count/time history and wrap-corrected delta
// depends on ess_pkg
`default_nettype none

module ess_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ess_pkg::TIME_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ess_pkg::TIME_W-1:0] in_now_us,
  input  wire logic [ess_pkg::COUNT_W-1:0] in_count,
  input  wire logic                       q_ready,
  output logic                            q_push,
  output ess_pkg::ess_item_t              q_item
);
  import ess_pkg::*;

  logic [TIME_W-1:0]         period_r;
  logic [COUNT_W-1:0]        cur_count_r;
  logic [TIME_W-1:0]         cur_time_r;
  logic signed [DELTA_W-1:0] last_delta_r;
  logic [TIME_W-1:0]         last_dt_r;

  logic [TIME_W-1:0]         elapsed;
  logic                      take;
  logic                      accept;
  logic signed [DELTA_W-1:0] raw_delta;
  logic signed [DELTA_W-1:0] delta_nxt;

  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;
  assign elapsed  = in_now_us - cur_time_r;
  assign take     = (elapsed >= period_r);

  // raw difference, then fold back one counter span
  always_comb begin
    raw_delta = $signed({2'b00, in_count}) - $signed({2'b00, cur_count_r});
    if (raw_delta <= -ESS_HALF) begin
      delta_nxt = raw_delta + ESS_WRAP;
    end else if (raw_delta >= ESS_HALF) begin
      delta_nxt = raw_delta - ESS_WRAP;
    end else begin
      delta_nxt = raw_delta;
    end
  end

  always_comb begin
    q_push         = accept;
    q_item.sampled = take;
    q_item.delta   = take ? delta_nxt : last_delta_r;
    q_item.dt      = take ? elapsed   : last_dt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= ESS_PERIOD_RST;
      cur_count_r  <= '0;
      cur_time_r   <= '0;
      last_delta_r <= '0;
      last_dt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (accept && take) begin
        cur_count_r  <= in_count;
        cur_time_r   <= in_now_us;
        last_delta_r <= delta_nxt;
        last_dt_r    <= elapsed;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ess_queue.sv
// ess_queue: small fifo of classified beats between front and back
// depends on ess_pkg
`default_nettype none

module ess_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire ess_pkg::ess_item_t     push_item,
  output logic                        ready,
  input  wire logic                   pop,
  output logic                        valid,
  output ess_pkg::ess_item_t          pop_item
);
  import ess_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ess_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   fill_r;
  logic            do_push;
  logic            do_pop;

  assign ready    = (fill_r != CW'(DEPTH));
  assign valid    = (fill_r != '0);
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ess_back.sv
// ess_back: speed computation (scale multiply, restoring divide, saturate) and result register
// depends on ess_pkg
`default_nettype none

module ess_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire ess_pkg::ess_item_t          q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_sampled,
  output logic signed [ess_pkg::SPEED_W-1:0] out_tick_speed,
  output logic signed [ess_pkg::DELTA_W-1:0] out_delta_ticks,
  output logic [ess_pkg::TIME_W-1:0]       out_delta_time,
  output logic                             out_zero_interval
);
  import ess_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam int SW = $clog2(MAG_W + 1);

  state_t                    state_r;
  ess_item_t                 item_r;
  logic [MAG_W-1:0]          quo_r;
  logic [TIME_W:0]           rem_r;
  logic [SW-1:0]             step_r;
  logic [SPEED_W-1:0]        speed_r;
  logic                      out_valid_r;
  logic                      sampled_r;
  logic [SPEED_W-1:0]        tick_speed_r;
  logic signed [DELTA_W-1:0] delta_ticks_r;
  logic [TIME_W-1:0]         delta_time_r;
  logic                      zero_r;

  logic                      neg;
  logic [DELTA_W-1:0]        abs_full;
  logic [ABS_W-1:0]          abs_delta;
  logic [MAG_W-1:0]          mag;
  logic [TIME_W:0]           rem_sh;
  logic                      ge;
  logic [TIME_W:0]           rem_nxt;
  logic [MAG_W-1:0]          quo_nxt;
  logic [SPEED_W-1:0]        sat_speed;
  logic [SPEED_W-1:0]        speed_nxt;
  logic                      out_free;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;

  // magnitude times the per-second scale
  always_comb begin
    neg       = item_r.delta[DELTA_W-1];
    abs_full  = neg ? DELTA_W'(-item_r.delta) : DELTA_W'(item_r.delta);
    abs_delta = abs_full[ABS_W-1:0];
    mag       = MAG_W'(abs_delta) * MAG_W'(ESS_SPEED_SCALE);
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r[TIME_W-1:0], quo_r[MAG_W-1]};
    ge      = (rem_sh >= {1'b0, item_r.dt});
    rem_nxt = ge ? (rem_sh - {1'b0, item_r.dt}) : rem_sh;
    quo_nxt = {quo_r[MAG_W-2:0], ge};
  end

  // clamp to the signed speed range, then pick what the stored speed becomes
  always_comb begin
    if (quo_r[MAG_W-1:SPEED_W-1] != '0) begin
      sat_speed = neg ? ESS_SPEED_MIN : ESS_SPEED_MAX;
    end else begin
      sat_speed = neg ? SPEED_W'(-quo_r[SPEED_W-1:0]) : quo_r[SPEED_W-1:0];
    end
    if (!item_r.sampled) begin
      speed_nxt = speed_r;
    end else if (item_r.dt == '0) begin
      speed_nxt = '0;
    end else begin
      speed_nxt = sat_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a taken beat empties the result register unless a new one loads now
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= (q_item.sampled && (q_item.dt != '0)) ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          quo_r   <= mag;
          rem_r   <= '0;
          step_r  <= SW'(MAG_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == SW'(1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            speed_r       <= speed_nxt;
            out_valid_r   <= 1'b1;
            sampled_r     <= item_r.sampled;
            tick_speed_r  <= speed_nxt;
            delta_ticks_r <= item_r.delta;
            delta_time_r  <= item_r.dt;
            zero_r        <= (item_r.dt == '0);
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sampled       = sampled_r;
  assign out_tick_speed    = $signed(tick_speed_r);
  assign out_delta_ticks   = delta_ticks_r;
  assign out_delta_time    = delta_time_r;
  assign out_zero_interval = zero_r;

endmodule

`default_nettype wire

### rtl/encoder_speed_sampler.sv
// encoder_speed_sampler: top level, front classifier + beat queue + speed back end
// depends on ess_pkg, ess_front, ess_queue, ess_back
`default_nettype none
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid / in_stall        | in_now_us[31:0], in_count[15:0]
//  out      | out_valid / out_stall      | out_sampled, out_tick_speed[35:0] (s),
//           |                            | out_delta_ticks[17:0] (s), out_delta_time,
//           |                            | out_zero_interval
//  cfg      | cfg_wr_en                  | cfg_wr_data[31:0] = sample period in us
//
//  a beat that takes a sample with nonzero interval passes through the back end as:
//    latch, one scale multiply, 37 restoring divide steps, result load
//  any other beat goes from latch straight to result load; the divider loop sets the rate
//  the front takes one beat per cycle while the queue (QUEUE_DEPTH beats) has room
//  synchronous active-low reset: period 10000 us, history and stored speed cleared
//  out_stall holds the result register and the back end's result load; front keeps filling the queue meanwhile

module encoder_speed_sampler #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [ess_pkg::TIME_W-1:0]    cfg_wr_data,
  // input beats
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ess_pkg::TIME_W-1:0]    in_now_us,
  input  wire logic [ess_pkg::COUNT_W-1:0]   in_count,
  // result beats
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_sampled,
  output logic signed [ess_pkg::SPEED_W-1:0] out_tick_speed,
  output logic signed [ess_pkg::DELTA_W-1:0] out_delta_ticks,
  output logic [ess_pkg::TIME_W-1:0]         out_delta_time,
  output logic                               out_zero_interval
);
  import ess_pkg::*;

  // front -> queue
  logic      push;
  ess_item_t push_item;
  logic      q_ready;
  // queue -> back
  logic      q_valid;
  ess_item_t pop_item;
  logic      q_pop;

  // decides whether a beat samples, keeps history, computes delta and interval
  ess_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_now_us   (in_now_us),
    .in_count    (in_count),
    .q_ready     (q_ready),
    .q_push      (push),
    .q_item      (push_item)
  );

  // decouples the one-per-cycle front from the multi-cycle divider
  ess_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  // speed = 1e6 * delta / dt, truncated and clamped, plus the result register
  ess_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sampled       (out_sampled),
    .out_tick_speed    (out_tick_speed),
    .out_delta_ticks   (out_delta_ticks),
    .out_delta_time    (out_delta_time),
    .out_zero_interval (out_zero_interval)
  );

endmodule

`default_nettype wire

### rtl/ess_checker.sv
// ess_checker: port-level checks of the encoder speed sampler, bound to the top level
// no package dependency; attaches to encoder_speed_sampler by bind
`default_nettype none

module ess_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_sampled,
  input wire logic signed [35:0] out_tick_speed,
  input wire logic signed [17:0] out_delta_ticks,
  input wire logic [31:0]        out_delta_time,
  input wire logic               out_zero_interval
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_tick_speed) && $stable(out_delta_ticks)
      && $stable(out_delta_time) && $stable(out_sampled) && $stable(out_zero_interval))
    else $error("result payload changed while stalled");

  // zero flag tracks the interval and forces the speed to zero
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_interval == (out_delta_time == 32'd0)))
    else $error("zero interval flag disagrees with delta time");

  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_interval |-> (out_tick_speed == 36'sd0))
    else $error("nonzero speed on zero interval");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind encoder_speed_sampler ess_checker u_ess_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sampled       (out_sampled),
  .out_tick_speed    (out_tick_speed),
  .out_delta_ticks   (out_delta_ticks),
  .out_delta_time    (out_delta_time),
  .out_zero_interval (out_zero_interval)
);

`default_nettype wire
